// ===== rtl/core/i2cebt_pkg.sv =====
package i2cebt_pkg;

  localparam int unsigned AckWait  = 250;
  localparam int unsigned MaxBytes = 64;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_DEVW   = 4'd2,
    PH_ADDR   = 4'd3,
    PH_DATA   = 4'd4,
    PH_DEVR   = 4'd5,
    PH_RSTART = 4'd6,
    PH_RX     = 4'd7,
    PH_MACK   = 4'd8,
    PH_STOP   = 4'd9,
    PH_ACK    = 4'd10
  } phase_t;

  // classified word passed from front to back
  typedef struct packed {
    logic       begin_xfer;
    logic       is_read;
    logic [7:0] mem_address;
    logic [6:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       data_request;
    logic [5:0] byte_index;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } res_t;

endpackage

// ===== rtl/core/i2cebt_front.sv =====
module i2cebt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        mode,
  input  logic [7:0]        mem_address,
  input  logic [6:0]        byte_count,
  input  logic [7:0]        write_data,
  input  logic              sda_in,
  output logic              q_valid,
  input  logic              q_ready,
  output i2cebt_pkg::cmd_t  q_cmd
);
  import i2cebt_pkg::*;

  cmd_t       mem_r [QDepth];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd;
  logic [6:0] cnt_clamped;

  // clamp count and classify mode
  always_comb begin
    if (byte_count == 7'd0) cnt_clamped = 7'd1;
    else if (byte_count > 7'(MaxBytes)) cnt_clamped = 7'(MaxBytes);
    else cnt_clamped = byte_count;
    cmd.begin_xfer  = (mode == MODE_WRITE) || (mode == MODE_READ);
    cmd.is_read     = (mode == MODE_READ);
    cmd.mem_address = mem_address;
    cmd.byte_count  = cnt_clamped;
    cmd.write_data  = write_data;
    cmd.sda_in      = sda_in;
  end

  assign in_tready = (cnt_r != 2'(QDepth));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  // hold queue words
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/i2cebt_back.sv =====
module i2cebt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              q_valid,
  output logic              q_ready,
  input  i2cebt_pkg::cmd_t  q_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output i2cebt_pkg::res_t  out_res
);
  import i2cebt_pkg::*;

  phase_t     ph_r, ph_nxt;
  phase_t     stage_r, stage_nxt;
  logic [1:0] t_r, t_nxt;
  logic [2:0] bc_r, bc_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [5:0] byc_r, byc_nxt;
  logic [6:0] tot_r, tot_nxt;
  logic [7:0] sa_r, sa_nxt;
  logic [3:0] att_r, att_nxt;
  logic [7:0] aw_r, aw_nxt;
  logic       rd_r, rd_nxt;
  logic       nack_r, nack_nxt;
  logic       ff_r, ff_nxt;
  logic [6:0] dev_r;
  logic [3:0] lim_r;
  logic       ov_r;
  res_t       res_r, res;
  logic       step, adv, mid, last;

  // skid-free output register: take a step when the slot frees up
  assign step       = q_valid && (!ov_r || out_tready);
  assign q_ready    = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_res    = res_r;
  assign mid        = (t_r == 2'd1) || (t_r == 2'd2);
  assign last       = ({1'b0, byc_r} + 7'd1) >= tot_r;

  // bus sequencer for one tick
  always_comb begin
    ph_nxt = ph_r; stage_nxt = stage_r; t_nxt = t_r; bc_nxt = bc_r; sh_nxt = sh_r;
    byc_nxt = byc_r; tot_nxt = tot_r; sa_nxt = sa_r; att_nxt = att_r; aw_nxt = aw_r;
    rd_nxt = rd_r; nack_nxt = nack_r; ff_nxt = ff_r;
    adv = 1'b1;
    res = '0;
    res.scl_level = 1'b1;
    res.sda_release = 1'b1;
    case (ph_r)
      PH_IDLE: begin
        adv = 1'b0;
        if (q_cmd.begin_xfer) begin
          rd_nxt = q_cmd.is_read; sa_nxt = q_cmd.mem_address;
          tot_nxt = q_cmd.byte_count; byc_nxt = 6'd0; bc_nxt = 3'd0;
          att_nxt = (lim_r == 4'd0) ? 4'd1 : lim_r;
          ff_nxt = 1'b0; ph_nxt = PH_START; t_nxt = 2'd0;
        end
      end
      PH_START, PH_RSTART: begin
        res.scl_level = mid;
        res.sda_release = (t_r < 2'd2);
        if (t_r == 2'd3) begin
          bc_nxt = 3'd0;
          if (ph_r == PH_START) begin
            sh_nxt = {dev_r, 1'b0}; ph_nxt = PH_DEVW;
          end else begin
            sh_nxt = {dev_r, 1'b1}; ph_nxt = PH_DEVR;
          end
        end
      end
      PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
        logic [7:0] s;
        s = sh_r;
        if (ph_r == PH_DATA && t_r == 2'd0 && bc_r == 3'd0) s = q_cmd.write_data;
        res.scl_level = mid;
        res.sda_release = s[7];
        sh_nxt = s;
        if (t_r == 2'd3) begin
          sh_nxt = {s[6:0], 1'b0};
          if (bc_r == 3'd7) begin
            bc_nxt = 3'd0; stage_nxt = ph_r; ph_nxt = PH_ACK;
          end else bc_nxt = bc_r + 3'd1;
        end
      end
      PH_ACK: begin
        res.scl_level = mid;
        case (t_r)
          2'd0: begin
            aw_nxt = 8'd0; nack_nxt = 1'b0;
          end
          2'd2: begin
            if (!q_cmd.sda_in) nack_nxt = 1'b0;
            else if (aw_r >= 8'(AckWait)) nack_nxt = 1'b1;
            else begin
              aw_nxt = aw_r + 8'd1; adv = 1'b0;
            end
          end
          2'd3: begin
            bc_nxt = 3'd0;
            if (nack_r) begin
              if (att_r > 4'd1) begin
                att_nxt = att_r - 4'd1; byc_nxt = 6'd0; ph_nxt = PH_START;
              end else begin
                ff_nxt = 1'b1; ph_nxt = PH_STOP;
              end
            end else begin
              case (stage_r)
                PH_DEVW: begin
                  sh_nxt = sa_r; ph_nxt = PH_ADDR;
                end
                PH_ADDR: begin
                  if (rd_r) ph_nxt = PH_RSTART;
                  else begin
                    ph_nxt = PH_DATA; res.data_request = 1'b1;
                  end
                end
                PH_DATA: begin
                  if (last) ph_nxt = PH_STOP;
                  else begin
                    byc_nxt = byc_r + 6'd1; ph_nxt = PH_DATA; res.data_request = 1'b1;
                  end
                end
                default: begin
                  sh_nxt = 8'd0; ph_nxt = PH_RX;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      PH_RX: begin
        logic [7:0] s;
        s = sh_r;
        res.scl_level = mid;
        if (t_r == 2'd2) s = {sh_r[6:0], q_cmd.sda_in};
        sh_nxt = s;
        if (t_r == 2'd3) begin
          if (bc_r == 3'd7) begin
            res.read_valid = 1'b1; res.read_data = s;
            bc_nxt = 3'd0; ph_nxt = PH_MACK;
          end else bc_nxt = bc_r + 3'd1;
        end
      end
      PH_MACK: begin
        res.scl_level = mid;
        res.sda_release = last;
        if (t_r == 2'd3) begin
          if (last) ph_nxt = PH_STOP;
          else begin
            byc_nxt = byc_r + 6'd1; sh_nxt = 8'd0; bc_nxt = 3'd0; ph_nxt = PH_RX;
          end
        end
      end
      PH_STOP: begin
        res.scl_level = (t_r >= 2'd1);
        res.sda_release = (t_r >= 2'd2);
        if (t_r == 2'd3) begin
          res.done_res = 1'b1; res.failed = ff_r;
          ph_nxt = PH_IDLE; adv = 1'b0; t_nxt = 2'd0;
        end
      end
      default: begin
        ph_nxt = PH_IDLE; t_nxt = 2'd0; adv = 1'b0;
      end
    endcase
    if (adv) t_nxt = t_r + 2'd1;
    res.byte_index = byc_nxt;
    res.busy_res = (ph_nxt != PH_IDLE);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= 7'd80;
      lim_r <= 4'd3;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) dev_r <= cfg_data;
      else lim_r <= cfg_data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; stage_r <= PH_IDLE; t_r <= '0; bc_r <= '0; sh_r <= '0;
      byc_r <= '0; tot_r <= '0; sa_r <= '0; att_r <= '0; aw_r <= '0;
      rd_r <= 1'b0; nack_r <= 1'b0; ff_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        ph_r <= ph_nxt; stage_r <= stage_nxt; t_r <= t_nxt; bc_r <= bc_nxt;
        sh_r <= sh_nxt; byc_r <= byc_nxt; tot_r <= tot_nxt; sa_r <= sa_nxt;
        att_r <= att_nxt; aw_r <= aw_nxt; rd_r <= rd_nxt; nack_r <= nack_nxt;
        ff_r <= ff_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/i2c_eeprom_block_transfer_master_unit.sv =====
// I2C master for serial EEPROM block transfers, driven by one bus tick per word.
// Input channel in_*: one word per prescaler tick. mode 0 ticks the bus,
// mode 1 begins a block write, mode 2 a block read (ignored while busy).
// Output channel out_*: exactly one result word per input word, carrying the
// SCL/SDA levels for that tick, data requests, received bytes and status.
// Each bus bit spans at least four ticks; a transfer restarts on device NACK until
// retry_limit attempts are spent, then ends with failed set alongside done.
// Configuration: cfg_we with cfg_index 0 (device address) or 1 (retry limit),
// to be written only while idle; the user must keep to this, the block does not enforce it.
// A word enters a two-entry queue, is stepped by the sequencer and its result
// is registered and presented on out_*. The block takes one word per cycle
// while the receiver does not stall the result register.
// Reset (rst_n low, synchronous) empties the queue, returns the bus to idle
// and loads device address 80 and retry limit 3.
// When the receiver stalls, the result register holds, the sequencer stops
// and the queue fills; in_tready drops once it holds two words.
module i2c_eeprom_block_transfer_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[1:0], mem_address[9:2], byte_count[16:10], write_data[24:17], sda_in[25]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level[0], sda_release[1], data_request[2], byte_index[8:3],
  // read_data[16:9], read_valid[17], busy_res[18], done_res[19], failed[20]
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import i2cebt_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  i2cebt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .mode        (in_tdata[1:0]),
    .mem_address (in_tdata[9:2]),
    .byte_count  (in_tdata[16:10]),
    .write_data  (in_tdata[24:17]),
    .sda_in      (in_tdata[25]),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd)
  );

  i2cebt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {3'b000, res.failed, res.done_res, res.busy_res, res.read_valid,
                      res.read_data, res.byte_index, res.data_request,
                      res.sda_release, res.scl_level};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import i2cebt_pkg::*;

  localparam int StallLimit = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // mode[1:0], mem_address[9:2], byte_count[16:10], write_data[24:17], sda_in[25]
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // scl_level[0], sda_release[1], data_request[2], byte_index[8:3],
  // read_data[16:9], read_valid[17], busy_res[18], done_res[19], failed[20]
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  i2c_eeprom_block_transfer_master_unit dut (.*);

  // bus sequencer mirror
  logic [6:0] m_dev;
  logic [3:0] m_retry;
  phase_t     m_ph;
  logic       m_ackbit;
  logic [1:0] m_tick;
  logic [2:0] m_bit;
  logic [7:0] m_shift;
  logic [5:0] m_byte;
  logic [6:0] m_total;
  logic [7:0] m_addr;
  logic [3:0] m_left;
  logic [7:0] m_wait;
  logic       m_rd;
  logic       m_nack;
  logic       m_fail;

  logic [31:0] word_q[$];
  logic [23:0] bus_q[$];
  int errors = 0;
  int cycles = 0;
  int n_done = 0;
  int n_fail = 0;
  int n_rx = 0;

  task automatic bus_reset();
    m_dev = 7'd80; m_retry = 4'd3; m_ph = PH_IDLE; m_ackbit = 0; m_tick = 0;
    m_bit = 0; m_shift = 0; m_byte = 0; m_total = 0; m_addr = 0; m_left = 0;
    m_wait = 0; m_rd = 0; m_nack = 0; m_fail = 0;
  endtask

  function automatic logic [23:0] bus_tick(logic [31:0] w);
    logic [1:0] md;
    logic [6:0] cnt;
    logic [1:0] t;
    logic scl, sdar, dreq, rv, dn, fl, adv, mid, sda, lst;
    logic [7:0] rdat;
    md = w[1:0]; cnt = w[16:10]; sda = w[25];
    t = m_tick; scl = 1; sdar = 1; dreq = 0; rv = 0; rdat = 0; dn = 0; fl = 0;
    adv = 1; mid = (t == 1 || t == 2);
    if (m_ackbit) begin
      scl = mid; sdar = 1;
      if (t == 0) begin
        m_wait = 0; m_nack = 0;
      end else if (t == 2) begin
        if (!sda) m_nack = 0;
        else if (m_wait >= AckWait) m_nack = 1;
        else begin
          m_wait++; adv = 0;
        end
      end else if (t == 3) begin
        m_bit = 0; m_ackbit = 0;
        if (m_nack) begin
          if (m_left > 1) begin
            m_left--; m_byte = 0; m_ph = PH_START;
          end else begin
            m_fail = 1; m_ph = PH_STOP;
          end
        end else if (m_ph == PH_DEVW) begin
          m_shift = m_addr; m_ph = PH_ADDR;
        end else if (m_ph == PH_ADDR) begin
          if (m_rd) m_ph = PH_RSTART;
          else begin
            m_ph = PH_DATA; dreq = 1;
          end
        end else if (m_ph == PH_DATA) begin
          if (7'(m_byte) + 1 >= m_total) m_ph = PH_STOP;
          else begin
            m_byte++; dreq = 1;
          end
        end else begin
          m_shift = 0; m_ph = PH_RX;
        end
      end
    end else begin
      case (m_ph)
        PH_IDLE: begin
          adv = 0;
          if (md == MODE_WRITE || md == MODE_READ) begin
            m_rd = (md == MODE_READ); m_addr = w[9:2];
            if (cnt == 0) cnt = 7'd1;
            if (cnt > MaxBytes) cnt = 7'(MaxBytes);
            m_total = cnt; m_byte = 0; m_bit = 0;
            m_left = (m_retry == 0) ? 4'd1 : m_retry;
            m_fail = 0; m_ph = PH_START; m_tick = 0;
          end
        end
        PH_START, PH_RSTART: begin
          scl = mid; sdar = (t < 2);
          if (t == 3) begin
            m_bit = 0;
            m_shift = {m_dev, m_ph == PH_RSTART};
            m_ph = (m_ph == PH_START) ? PH_DEVW : PH_DEVR;
          end
        end
        PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
          if (m_ph == PH_DATA && t == 0 && m_bit == 0) m_shift = w[24:17];
          scl = mid; sdar = m_shift[7];
          if (t == 3) begin
            m_shift = m_shift << 1;
            if (m_bit == 7) begin
              m_bit = 0; m_ackbit = 1;
            end else m_bit++;
          end
        end
        PH_RX: begin
          scl = mid;
          if (t == 2) m_shift = {m_shift[6:0], sda};
          if (t == 3) begin
            if (m_bit == 7) begin
              rv = 1; rdat = m_shift; m_bit = 0; m_ph = PH_MACK;
            end else m_bit++;
          end
        end
        PH_MACK: begin
          lst = (7'(m_byte) + 1 >= m_total);
          scl = mid; sdar = lst;
          if (t == 3) begin
            if (lst) m_ph = PH_STOP;
            else begin
              m_byte++; m_shift = 0; m_bit = 0; m_ph = PH_RX;
            end
          end
        end
        PH_STOP: begin
          scl = (t >= 1); sdar = (t >= 2);
          if (t == 3) begin
            dn = 1; fl = m_fail; m_ph = PH_IDLE; adv = 0; m_tick = 0;
          end
        end
        default: begin
          m_ph = PH_IDLE; m_tick = 0; adv = 0;
        end
      endcase
    end
    if (adv) m_tick = t + 2'd1;
    return {3'b0, fl, dn, (m_ph != PH_IDLE || m_ackbit), rv, rdat, m_byte, dreq, sdar, scl};
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= '0;
    end else if (in_tvalid && !in_tready) begin
      // hold the word until taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 0;
    end else if (word_q.size() > 0) begin
      in_tdata <= word_q[0];
      bus_q.push_back(bus_tick(word_q.pop_front()));
      in_tvalid <= 1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
      end else burst_left <= burst_left - 1;
    end else in_tvalid <= 0;
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_tready <= 1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // result check
  logic [23:0] want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        errors++;
      end else begin
        want = bus_q.pop_front();
        if (want[20:0] != out_tdata[20:0]) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_tdata);
          errors++;
        end
        if (want[19]) n_done++;
        if (want[20]) n_fail++;
        if (want[17]) n_rx++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] mk(logic [1:0] md, logic [7:0] a, logic [6:0] c,
                                     logic [7:0] d, logic s);
    return {6'b0, s, d, c, a, md};
  endfunction

  // queue one transfer: ack policy 0 mostly ack, 1 always nack, 2 random
  task automatic add_xfer(logic [1:0] md, logic [6:0] cnt, int pol);
    int ticks;
    ticks = 0;
    word_q.push_back(mk(md, 8'($urandom), cnt, 8'($urandom), 1'($urandom)));
    // keep ticking, with sda set by policy
    repeat (40 + 40 * ((cnt == 0) ? 1 : (cnt > 64 ? 64 : cnt))) begin
      case (pol)
        0: word_q.push_back(mk(MODE_TICK, 8'($urandom), 7'($urandom), 8'($urandom),
                               ($urandom_range(0, 3) == 0)));
        1: word_q.push_back(mk(MODE_TICK, 8'($urandom), 7'($urandom), 8'($urandom),
                               1'b1));
        default: word_q.push_back(mk(2'($urandom), 8'($urandom), 7'($urandom),
                                     8'($urandom), 1'($urandom)));
      endcase
    end
  endtask

  task automatic drain();
    wait (word_q.size() == 0);
    wait (bus_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    if (idx) m_retry = v[3:0];
    else m_dev = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic finish_idle();
    // run ticks until the mirror returns to idle
    while (m_ph != PH_IDLE || m_ackbit) begin
      word_q.push_back(mk(MODE_TICK, 8'd0, 7'd0, 8'd0, 1'b0));
      wait (word_q.size() == 0);
    end
    drain();
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    bus_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: write, read, zero count, reserved mode
    add_xfer(MODE_WRITE, 7'd1, 0);
    add_xfer(MODE_READ, 7'd2, 0);
    add_xfer(MODE_WRITE, 7'd0, 0);
    add_xfer(MODE_RSVD, 7'd3, 0);
    drain(); finish_idle();
    // nack with one retry
    cfg_write(1'b0, 7'h7f); cfg_write(1'b1, 7'd2);
    add_xfer(MODE_WRITE, 7'd2, 1);
    drain(); finish_idle();
    // retry limit zero taken as one attempt
    cfg_write(1'b0, 7'h00); cfg_write(1'b1, 7'd0);
    add_xfer(MODE_WRITE, 7'd3, 1);
    drain(); finish_idle();
    // random phases with changing settings
    repeat (2) begin
      cfg_write(1'b0, 7'($urandom)); cfg_write(1'b1, 7'($urandom_range(1, 4)));
      repeat (2) add_xfer(2'($urandom_range(1, 2)), 7'($urandom_range(0, 4)),
                          $urandom_range(0, 9) == 0 ? 2 : 0);
      drain(); finish_idle();
    end
    cfg_write(1'b0, 7'd80); cfg_write(1'b1, 7'd3);
    finish_idle();
    $display("transfers completed %0d, failed %0d, bytes received %0d",
             n_done, n_fail, n_rx);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== i2c_eeprom_block_transfer_master_unit.f =====
rtl/core/i2cebt_pkg.sv
rtl/core/i2cebt_front.sv
rtl/core/i2cebt_back.sv
rtl/core/i2c_eeprom_block_transfer_master_unit.sv
tb/tb.sv
